// ===== rtl/minmax_bin_partition_dp_macros.svh =====
// Assertion helpers for the checker file of this block.
`ifndef MINMAX_BIN_PARTITION_DP_MACROS_SVH
`define MINMAX_BIN_PARTITION_DP_MACROS_SVH

// Same-cycle implication, sampled on aclk and quiet during reset.
`define MMBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and quiet during reset.
`define MMBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mmbp_pkg.sv =====
package mmbp_pkg;

    localparam int CNT_W      = 7;
    localparam int COST_W     = 48;
    localparam int CORR_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int ID_W       = 16;
    localparam int FIRST_W    = 6;
    localparam int CORR_DEPTH = 64;
    localparam int CORR_AW    = 6;
    localparam int PROD_W     = 64;
    localparam int FRAC_W     = 16;
    localparam int DIV_W      = 48;
    localparam int DIVR_W     = 7;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = DIV_W / DIV_BITS;
    localparam int DIV_CW     = $clog2(DIV_STEPS);

    localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_A_RD,
        ST_A_MUL,
        ST_A_DIV,
        ST_A_WAIT,
        ST_D_RD,
        ST_D_CMP,
        ST_B_RD,
        ST_B_DIV,
        ST_B_WAIT,
        ST_F_DIV,
        ST_F_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/mmbp_div.sv =====
module mmbp_div
    import mmbp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] step_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] dvs_reg;

    logic [DIV_W-1:0]  quo_next;
    logic [DIVR_W-1:0] rem_next;
    logic [DIVR_W:0]   shifted;
    logic [DIVR_W:0]   diff;

    // Restoring division, DIV_BITS quotient bits per cycle.
    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        shifted  = '0;
        diff     = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            shifted  = {rem_next, quo_next[DIV_W-1]};
            quo_next = {quo_next[DIV_W-2:0], 1'b0};
            diff     = shifted - {1'b0, dvs_reg};
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next    = diff[DIVR_W-1:0];
                quo_next[0] = 1'b1;
            end else begin
                rem_next = shifted[DIVR_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + DIV_CW'(1);
                if (step_reg == DIV_CW'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/minmax_bin_partition_dp.sv =====
// Load items: one per cycle in idle, no result; a bin item flagged last starts the pass.
// Pass: per column and run length the load value takes one 32x32 multiply,
// then the divider; each predecessor candidate is read from the cost and load
// memories and compared, then one divide is done per result.
// Input is taken again only after the last result beat is accepted.
// Reset (synchronous, aresetn low): technical_bins = MAX_TECH_BINS, no bins loaded.
module minmax_bin_partition_dp
    import mmbp_pkg::*;
#(
    parameter int MAX_TECH_BINS = 64,
    parameter int MAX_USER_BINS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [CNT_W-1:0]   s_run_length,
    input  logic [CORR_W-1:0]  s_correction,
    input  logic [ID_W-1:0]    s_user_bin,
    input  logic [COUNT_W-1:0] s_count,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [ID_W-1:0]    m_user_bin_out,
    output logic [CNT_W-1:0]   m_bin_run,
    output logic [FIRST_W-1:0] m_first_bin,
    output logic [FIRST_W-1:0] m_largest_start,
    output logic               m_error,
    output logic               m_end_of_run
);

    localparam int TI_W  = $clog2(MAX_TECH_BINS);
    localparam int UJ_W  = (MAX_USER_BINS > 1) ? $clog2(MAX_USER_BINS) : 1;
    localparam int TR_AW = TI_W + UJ_W;
    localparam logic [CNT_W-1:0] MT_C = CNT_W'(MAX_TECH_BINS);
    localparam logic [CNT_W-1:0] MU_C = CNT_W'(MAX_USER_BINS);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    // Memories
    logic [CORR_W-1:0]  corr_mem  [CORR_DEPTH];
    logic [COUNT_W-1:0] cnt_mem   [MAX_USER_BINS];
    logic [ID_W-1:0]    id_mem    [MAX_USER_BINS];
    logic [COST_W-1:0]  load_mem  [MAX_TECH_BINS];
    logic [COST_W-1:0]  cost_mem  [2**(TI_W+1)];
    logic [TI_W-1:0]    trace_mem [2**TR_AW];

    logic [CORR_W-1:0]  corr_rd_reg;
    logic [COUNT_W-1:0] cnt_rd_reg;
    logic [ID_W-1:0]    id_rd_reg;
    logic [COST_W-1:0]  load_rd_reg;
    logic [COST_W-1:0]  cost_rd_reg;
    logic [TI_W-1:0]    trace_rd_reg;

    // Control registers
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] tech_reg;
    logic [CNT_W-1:0] loaded_reg, loaded_next;
    logic             m_valid_reg, m_valid_next;

    // Payload registers
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   extra_reg, extra_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   ip_reg, ip_next;
    logic [COST_W-1:0]  best_reg, best_next;
    logic [TI_W-1:0]    tr_reg, tr_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [CNT_W-1:0]   ti_reg, ti_next;
    logic [CNT_W-1:0]   tj_reg, tj_next;
    logic [CNT_W-1:0]   nx_reg, nx_next;
    logic [CNT_W-1:0]   nb_reg, nb_next;
    logic [CNT_W-1:0]   bin_id_reg, bin_id_next;
    logic [COST_W-1:0]  peak_per_reg, peak_per_next;
    logic [CNT_W-1:0]   max_id_reg, max_id_next;
    logic [ID_W-1:0]    o_id_reg, o_id_next;
    logic [CNT_W-1:0]   o_run_reg, o_run_next;
    logic [CNT_W-1:0]   o_first_reg, o_first_next;
    logic [CNT_W-1:0]   o_largest_reg, o_largest_next;
    logic               o_err_reg, o_err_next;
    logic               o_eor_reg, o_eor_next;

    // Memory ports
    logic [CNT_W-1:0]  bin_addr;
    logic [CNT_W-1:0]  load_addr;
    logic [TI_W:0]     cost_raddr;
    logic              cost_we;
    logic [TI_W:0]     cost_waddr;
    logic [COST_W-1:0] cost_wdata;
    logic              load_we;
    logic              trace_we;
    logic [TI_W-1:0]   trace_wdata;

    logic              s_acc;
    logic              cfg_wr;
    logic [CNT_W-1:0]  cfg_val;
    logic [CNT_W-1:0]  rl_m1;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [COST_W-1:0]  dp_s;
    logic               dp_better;
    logic [COST_W-1:0]  best_new;
    logic [TI_W-1:0]    tr_new;
    logic [CNT_W-1:0]   nx_c;
    logic [CNT_W-1:0]   nb_c;
    logic [COUNT_W:0]   ceil_sum;
    logic               pass_err;

    mmbp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && !paddr[2];
    assign cfg_val = pwdata[CNT_W-1:0];
    assign prdata  = paddr[2] ? 32'd0 : {{(32 - CNT_W){1'b0}}, tech_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tech_reg <= MT_C;
        end else if (cfg_wr) begin
            if (cfg_val == '0) begin
                tech_reg <= ONE;
            end else if (cfg_val > MT_C) begin
                tech_reg <= MT_C;
            end else begin
                tech_reg <= cfg_val;
            end
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc   = s_valid && s_ready;
    assign rl_m1   = s_run_length - ONE;

    // Load-phase writes
    always_ff @(posedge aclk) begin
        if (s_acc && !s_func && s_run_length != '0 && s_run_length <= CNT_W'(CORR_DEPTH)) begin
            corr_mem[rl_m1[CORR_AW-1:0]] <= s_correction;
        end
        if (s_acc && s_func && loaded_reg < MU_C) begin
            cnt_mem[loaded_reg[UJ_W-1:0]] <= s_count;
            id_mem[loaded_reg[UJ_W-1:0]]  <= s_user_bin;
        end
    end

    // Read addresses follow the sequencer's counters.
    assign bin_addr   = (state_reg == ST_B_RD) ? tj_reg : j_reg;
    assign load_addr  = i_reg - ip_reg - ONE;
    assign cost_raddr = {~j_reg[0], ip_reg[TI_W-1:0]};

    always_ff @(posedge aclk) begin
        corr_rd_reg  <= corr_mem[len_reg[CORR_AW-1:0] - CORR_AW'(1)];
        cnt_rd_reg   <= cnt_mem[bin_addr[UJ_W-1:0]];
        id_rd_reg    <= id_mem[bin_addr[UJ_W-1:0]];
        load_rd_reg  <= load_mem[load_addr[TI_W-1:0]];
        cost_rd_reg  <= cost_mem[cost_raddr];
        trace_rd_reg <= trace_mem[{ti_reg[TI_W-1:0], tj_reg[UJ_W-1:0]}];
    end

    // The previous column is read while the current one is written; the two
    // columns never share an address, so no forwarding is needed.
    always_ff @(posedge aclk) begin
        if (load_we) begin
            load_mem[len_reg[TI_W-1:0] - TI_W'(1)] <= div_rsp.quotient;
        end
        if (cost_we) begin
            cost_mem[cost_waddr] <= cost_wdata;
        end
        if (trace_we) begin
            trace_mem[{i_reg[TI_W-1:0], j_reg[UJ_W-1:0]}] <= trace_wdata;
        end
    end

    // Candidate compare for one predecessor.
    assign dp_s      = (load_rd_reg > cost_rd_reg) ? load_rd_reg : cost_rd_reg;
    assign dp_better = dp_s < best_reg;
    assign best_new  = dp_better ? dp_s : best_reg;
    assign tr_new    = dp_better ? ip_reg[TI_W-1:0] : tr_reg;

    assign nx_c     = ({{(CNT_W - TI_W){1'b0}}, trace_rd_reg} >= ti_reg) ? ti_reg - ONE
                    : {{(CNT_W - TI_W){1'b0}}, trace_rd_reg};
    assign nb_c     = ti_reg - nx_c;
    assign pass_err = (loaded_reg == '0) || (loaded_reg > tech_reg) || (loaded_reg > MU_C);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            loaded_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            loaded_reg  <= loaded_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        extra_reg     <= extra_next;
        j_reg         <= j_next;
        len_reg       <= len_next;
        i_reg         <= i_next;
        ip_reg        <= ip_next;
        best_reg      <= best_next;
        tr_reg        <= tr_next;
        prod_reg      <= prod_next;
        ti_reg        <= ti_next;
        tj_reg        <= tj_next;
        nx_reg        <= nx_next;
        nb_reg        <= nb_next;
        bin_id_reg    <= bin_id_next;
        peak_per_reg  <= peak_per_next;
        max_id_reg    <= max_id_next;
        o_id_reg      <= o_id_next;
        o_run_reg     <= o_run_next;
        o_first_reg   <= o_first_next;
        o_largest_reg <= o_largest_next;
        o_err_reg     <= o_err_next;
        o_eor_reg     <= o_eor_next;
    end

    always_comb begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        m_valid_next   = m_valid_reg;
        n_next         = n_reg;
        extra_next     = extra_reg;
        j_next         = j_reg;
        len_next       = len_reg;
        i_next         = i_reg;
        ip_next        = ip_reg;
        best_next      = best_reg;
        tr_next        = tr_reg;
        prod_next      = prod_reg;
        ti_next        = ti_reg;
        tj_next        = tj_reg;
        nx_next        = nx_reg;
        nb_next        = nb_reg;
        bin_id_next    = bin_id_reg;
        peak_per_next  = peak_per_reg;
        max_id_next    = max_id_reg;
        o_id_next      = o_id_reg;
        o_run_next     = o_run_reg;
        o_first_next   = o_first_reg;
        o_largest_next = o_largest_reg;
        o_err_next     = o_err_reg;
        o_eor_next     = o_eor_reg;
        load_we        = 1'b0;
        cost_we        = 1'b0;
        cost_waddr     = '0;
        cost_wdata     = div_rsp.quotient;
        trace_we       = 1'b0;
        trace_wdata    = tr_new;
        ceil_sum       = '0;
        div_req        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_func) begin
                    if (loaded_reg < MU_C) begin
                        loaded_next = loaded_reg + ONE;
                    end else begin
                        loaded_next = MU_C + ONE;
                    end
                    if (s_last) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                loaded_next   = '0;
                n_next        = loaded_reg;
                extra_next    = tech_reg - loaded_reg + ONE;
                j_next        = '0;
                len_next      = ONE;
                ti_next       = tech_reg - ONE;
                tj_next       = loaded_reg - ONE;
                bin_id_next   = '0;
                peak_per_next = '0;
                max_id_next   = '0;
                if (pass_err) begin
                    o_id_next      = '0;
                    o_run_next     = '0;
                    o_first_next   = '0;
                    o_largest_next = '0;
                    o_err_next     = 1'b1;
                    o_eor_next     = 1'b1;
                    m_valid_next   = 1'b1;
                    state_next     = ST_OUT;
                end else begin
                    state_next = ST_A_RD;
                end
            end
            ST_A_RD: begin
                state_next = ST_A_MUL;
            end
            ST_A_MUL: begin
                prod_next  = PROD_W'(cnt_rd_reg) * PROD_W'(corr_rd_reg);
                state_next = ST_A_DIV;
            end
            ST_A_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg[PROD_W-1:FRAC_W];
                div_req.divisor  = len_reg;
                state_next       = ST_A_WAIT;
            end
            ST_A_WAIT: begin
                if (div_rsp.done) begin
                    load_we = 1'b1;
                    if (j_reg == '0) begin
                        // The first column is the load of a single run.
                        cost_we    = 1'b1;
                        cost_waddr = {1'b0, len_reg[TI_W-1:0] - TI_W'(1)};
                    end
                    if (len_reg == extra_reg) begin
                        if (j_reg == '0) begin
                            if (n_reg == ONE) begin
                                state_next = ST_B_RD;
                            end else begin
                                j_next     = ONE;
                                len_next   = ONE;
                                state_next = ST_A_RD;
                            end
                        end else begin
                            i_next     = j_reg;
                            ip_next    = j_reg - ONE;
                            best_next  = COST_INF;
                            tr_next    = ip_next[TI_W-1:0];
                            state_next = ST_D_RD;
                        end
                    end else begin
                        len_next   = len_reg + ONE;
                        state_next = ST_A_RD;
                    end
                end
            end
            ST_D_RD: begin
                state_next = ST_D_CMP;
            end
            ST_D_CMP: begin
                best_next = best_new;
                tr_next   = tr_new;
                if (ip_reg == i_reg - ONE) begin
                    cost_we    = 1'b1;
                    cost_waddr = {j_reg[0], i_reg[TI_W-1:0]};
                    cost_wdata = best_new;
                    trace_we   = 1'b1;
                    if (i_reg == j_reg + extra_reg - ONE) begin
                        if (j_reg + ONE == n_reg) begin
                            state_next = ST_B_RD;
                        end else begin
                            j_next     = j_reg + ONE;
                            len_next   = ONE;
                            state_next = ST_A_RD;
                        end
                    end else begin
                        i_next     = i_reg + ONE;
                        ip_next    = j_reg - ONE;
                        best_next  = COST_INF;
                        tr_next    = ip_next[TI_W-1:0];
                        state_next = ST_D_RD;
                    end
                end else begin
                    ip_next    = ip_reg + ONE;
                    state_next = ST_D_RD;
                end
            end
            ST_B_RD: begin
                if (tj_reg == '0) begin
                    state_next = ST_F_DIV;
                end else begin
                    state_next = ST_B_DIV;
                end
            end
            ST_B_DIV: begin
                ceil_sum         = {1'b0, cnt_rd_reg} + (COUNT_W + 1)'(nb_c) - (COUNT_W + 1)'(1);
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(ceil_sum);
                div_req.divisor  = nb_c;
                nx_next          = nx_c;
                nb_next          = nb_c;
                o_id_next        = id_rd_reg;
                state_next       = ST_B_WAIT;
            end
            ST_B_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient > peak_per_reg) begin
                        peak_per_next = div_rsp.quotient;
                        max_id_next   = bin_id_reg;
                    end
                    o_run_next     = nb_reg;
                    o_first_next   = bin_id_reg;
                    o_largest_next = '0;
                    o_err_next     = 1'b0;
                    o_eor_next     = 1'b0;
                    m_valid_next   = 1'b1;
                    bin_id_next    = bin_id_reg + nb_reg;
                    ti_next        = nx_reg;
                    tj_next        = tj_reg - ONE;
                    state_next     = ST_OUT;
                end
            end
            ST_F_DIV: begin
                ceil_sum         = {1'b0, cnt_rd_reg} + (COUNT_W + 1)'(ti_reg);
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(ceil_sum);
                div_req.divisor  = ti_reg + ONE;
                nb_next          = ti_reg + ONE;
                o_id_next        = id_rd_reg;
                state_next       = ST_F_WAIT;
            end
            ST_F_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient > peak_per_reg) begin
                        o_largest_next = bin_id_reg;
                    end else begin
                        o_largest_next = max_id_reg;
                    end
                    o_run_next   = nb_reg;
                    o_first_next = bin_id_reg;
                    o_err_next   = 1'b0;
                    o_eor_next   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (o_eor_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_B_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_user_bin_out  = o_id_reg;
    assign m_bin_run       = o_run_reg;
    assign m_first_bin     = o_first_reg[FIRST_W-1:0];
    assign m_largest_start = o_largest_reg[FIRST_W-1:0];
    assign m_error         = o_err_reg;
    assign m_end_of_run    = o_eor_reg;

endmodule

// ===== rtl/mmbp_checker.sv =====
`include "minmax_bin_partition_dp_macros.svh"

module mmbp_checker
    import mmbp_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [CNT_W-1:0]   m_bin_run,
    input logic [FIRST_W-1:0] m_largest_start,
    input logic               m_error,
    input logic               m_end_of_run
);

    // A result beat that waits keeps its run length.
    `MMBP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_bin_run), "result dropped or changed while stalled")

    // Input is closed while the layout is being delivered.
    `MMBP_ASSERT_NOW(a_no_overlap, m_valid, !s_ready, "input open while a result is pending")

    // The error beat stands alone and is empty.
    `MMBP_ASSERT_NOW(a_err_beat, m_valid && m_error, m_end_of_run && m_bin_run == '0, "malformed error beat")

    // Every placed user bin owns at least one technical bin.
    `MMBP_ASSERT_NOW(a_run_nonzero, m_valid && !m_error, m_bin_run != '0, "empty run in layout")

    // The largest-bin start is reported on the last beat only.
    `MMBP_ASSERT_NOW(a_largest_last, m_valid && !m_end_of_run, m_largest_start == '0, "largest start before the last beat")

endmodule

bind minmax_bin_partition_dp mmbp_checker u_mmbp_checker (.*);

// ===== test/minmax_bin_partition_dp_test.sv =====
module minmax_bin_partition_dp_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mmbp_pkg::*;

    localparam logic FUNC_CORR = 1'b0;
    localparam logic FUNC_BIN  = 1'b1;
    localparam logic [2:0] ADDR_TECH_BINS = 3'd0;
    localparam logic [2:0] ADDR_UNUSED    = 3'd4;
    localparam int TECH_MAX = 64;
    localparam int USER_MAX = 64;
    localparam int ITEM_TARGET = 310;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [CNT_W-1:0]   run;
        logic [FIRST_W-1:0] first;
        logic [FIRST_W-1:0] largest;
        logic               err;
        logic               eor;
    } placement_t;

    typedef struct packed {
        row_kind_t          kind;
        logic               func;
        logic [CNT_W-1:0]   rl;
        logic [31:0]        corr;
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] cnt;
        logic               last;
        logic               typed;
        placement_t         want;
    } load_row_t;

    logic aclk, aresetn;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic s_valid, s_ready, s_func, s_last;
    logic [CNT_W-1:0] s_run_length;
    logic [CORR_W-1:0] s_correction;
    logic [ID_W-1:0] s_user_bin;
    logic [COUNT_W-1:0] s_count;
    logic m_valid, m_ready, m_error, m_end_of_run;
    logic [ID_W-1:0] m_user_bin_out;
    logic [CNT_W-1:0] m_bin_run;
    logic [FIRST_W-1:0] m_first_bin, m_largest_start;

    minmax_bin_partition_dp DUT (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_run_length(s_run_length), .s_correction(s_correction),
        .s_user_bin(s_user_bin), .s_count(s_count), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_user_bin_out(m_user_bin_out),
        .m_bin_run(m_bin_run), .m_first_bin(m_first_bin),
        .m_largest_start(m_largest_start), .m_error(m_error),
        .m_end_of_run(m_end_of_run)
    );

    // Predictor state.
    logic [CORR_W-1:0]  corr_tab [CORR_DEPTH];
    logic [COUNT_W-1:0] bin_cnt [USER_MAX];
    logic [ID_W-1:0]    bin_id [USER_MAX];
    int unsigned        bins_loaded = 0;
    int unsigned        tech_bins = TECH_MAX;

    placement_t layout_beats[$];
    placement_t pending_placements[$];
    load_row_t  offer_q[$];
    load_row_t  in_flight_q[$];
    int  failures = 0;
    int  burst_left = 0;
    bit  hold_req = 0;

    function automatic logic [COST_W-1:0] corrected_load(logic [31:0] c, int unsigned len);
        logic [63:0] p;
        p = ({32'b0, c} * {32'b0, corr_tab[len-1]}) >> 16;
        return COST_W'(p / len);
    endfunction

    function automatic void plan_layout();
        int unsigned n, t, extra, i, j, ip, ti, tj, nx, nb, first, max_id;
        logic [63:0] peak_per, per;
        logic [COST_W-1:0] prev [TECH_MAX];
        logic [COST_W-1:0] cur [TECH_MAX];
        logic [COST_W-1:0] a, s, best;
        logic [5:0] trace [TECH_MAX][USER_MAX];
        placement_t b;
        n = bins_loaded;
        t = tech_bins;
        bins_loaded = 0;
        layout_beats.delete();
        b = '0;
        if (n == 0 || n > t || n > USER_MAX) begin
            b.err = 1'b1;
            b.eor = 1'b1;
            layout_beats.push_back(b);
            return;
        end
        extra = t - n + 1;
        for (i = 0; i < TECH_MAX; i++) prev[i] = COST_INF;
        for (i = 0; i < extra; i++) prev[i] = corrected_load(bin_cnt[0], i + 1);
        for (j = 1; j < n; j++) begin
            for (i = 0; i < TECH_MAX; i++) cur[i] = COST_INF;
            for (i = j; i < j + extra; i++) begin
                best = COST_INF;
                trace[i][j] = 6'(j - 1);
                // Strict compare keeps the smallest predecessor on a tie.
                for (ip = j - 1; ip < i; ip++) begin
                    a = corrected_load(bin_cnt[j], i - ip);
                    s = (a > prev[ip]) ? a : prev[ip];
                    if (s < best) begin
                        best = s;
                        trace[i][j] = 6'(ip);
                    end
                end
                cur[i] = best;
            end
            prev = cur;
        end
        ti = t - 1;
        tj = n - 1;
        first = 0;
        max_id = 0;
        peak_per = 0;
        while (tj > 0) begin
            nx = trace[ti][tj];
            if (nx >= ti) nx = ti - 1;
            nb = ti - nx;
            per = ({32'b0, bin_cnt[tj]} + nb - 1) / nb;
            b = '0;
            b.id = bin_id[tj];
            b.run = CNT_W'(nb);
            b.first = FIRST_W'(first);
            layout_beats.push_back(b);
            if (per > peak_per) begin
                max_id = first;
                peak_per = per;
            end
            first += nb;
            ti = nx;
            tj--;
        end
        ti++;
        per = ({32'b0, bin_cnt[0]} + ti - 1) / ti;
        if (per > peak_per) max_id = first;
        b = '0;
        b.id = bin_id[0];
        b.run = CNT_W'(ti);
        b.first = FIRST_W'(first);
        b.largest = FIRST_W'(max_id);
        b.eor = 1'b1;
        layout_beats.push_back(b);
    endfunction

    // Accepted beats on both channels.
    always @(posedge aclk) begin
        load_row_t it;
        placement_t w;
        if (aresetn && s_valid && s_ready) begin
            it = in_flight_q.pop_front();
            if (s_func == FUNC_CORR) begin
                if (s_run_length >= 1 && s_run_length <= CORR_DEPTH)
                    corr_tab[s_run_length-1] = s_correction;
            end else begin
                if (bins_loaded < USER_MAX) begin
                    bin_id[bins_loaded] = s_user_bin;
                    bin_cnt[bins_loaded] = s_count;
                    bins_loaded++;
                end else begin
                    bins_loaded = USER_MAX + 1;
                end
                if (s_last) begin
                    plan_layout();
                    if (it.typed) begin
                        layout_beats.delete();
                        layout_beats.push_back(it.want);
                    end
                    foreach (layout_beats[k]) pending_placements.push_back(layout_beats[k]);
                end
            end
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_placements.size() == 0) begin
                $error("result beat with nothing expected");
                failures++;
            end else begin
                w = pending_placements.pop_front();
                if (m_user_bin_out !== w.id) begin
                    $error("user_bin_out: expected %0h, got %0h", w.id, m_user_bin_out);
                    failures++;
                end
                if (m_bin_run !== w.run) begin
                    $error("bin_run: expected %0d, got %0d", w.run, m_bin_run);
                    failures++;
                end
                if (m_first_bin !== w.first) begin
                    $error("first_bin: expected %0d, got %0d", w.first, m_first_bin);
                    failures++;
                end
                if (m_largest_start !== w.largest) begin
                    $error("largest_start: expected %0d, got %0d", w.largest,
                           m_largest_start);
                    failures++;
                end
                if (m_error !== w.err) begin
                    $error("error: expected %0b, got %0b", w.err, m_error);
                    failures++;
                end
                if (m_end_of_run !== w.eor) begin
                    $error("end_of_run: expected %0b, got %0b", w.eor, m_end_of_run);
                    failures++;
                end
            end
        end
    end

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: the stall pattern is redrawn whenever its mode counter runs out; a hold
    // request blocks results for a long stretch so the block backs up its input.
    initial begin
        int mode_cnt, mode, hold_cnt;
        mode_cnt = 0;
        mode = 0;
        hold_cnt = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && hold_cnt == 0) begin
                hold_cnt = 3000;
                hold_req = 0;
            end
            if (mode_cnt == 0) begin
                mode = $urandom_range(0, 3);
                mode_cnt = 64;
            end
            mode_cnt--;
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    2: m_ready <= (mode_cnt % 5 != 0);
                    default: m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Offers every queued item; valid is dropped only at a gap or at the end.
    task automatic flush_offers();
        load_row_t it;
        int gap;
        while (offer_q.size() > 0) begin
            it = offer_q.pop_front();
            in_flight_q.push_back(it);
            s_valid <= 1'b1;
            s_func <= it.func;
            s_run_length <= it.rl;
            s_correction <= it.corr;
            s_user_bin <= it.id;
            s_count <= it.cnt;
            s_last <= it.last;
            do @(negedge aclk); while (!s_ready);
            @(posedge aclk);
            if (offer_q.size() == 0 || burst_left == 0) begin
                s_valid <= 1'b0;
                gap = (offer_q.size() == 0) ? 1 : $urandom_range(1, 6);
                repeat (gap) @(posedge aclk);
                burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic write_tech_bins(logic [2:0] addr, logic [31:0] value);
        logic [6:0] v;
        @(negedge aclk);
        while (pending_placements.size() != 0) @(negedge aclk);
        // A correction beat can still be in flight after the last result.
        repeat (40) @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (addr == ADDR_TECH_BINS) begin
            v = value[6:0];
            if (v == 7'd0) v = 7'd1;
            if (v > 7'(TECH_MAX)) v = 7'(TECH_MAX);
            tech_bins = 32'(v);
        end
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= ADDR_TECH_BINS;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        if (prdata !== 32'(tech_bins)) begin
            $error("technical_bins: expected %0d, got %0d", tech_bins, prdata);
            failures++;
        end
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic load_row_t mk_row(row_kind_t kind, logic func, logic [6:0] rl,
                                         logic [31:0] corr, logic [15:0] id,
                                         logic [31:0] cnt, logic last);
        load_row_t r;
        r = '0;
        r.kind = kind;
        r.func = func;
        r.rl = rl;
        r.corr = corr;
        r.id = id;
        r.cnt = cnt;
        r.last = last;
        return r;
    endfunction

    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 20);
            3: return $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_corr();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0001_0000;
            3: return $urandom_range(32'h8000, 32'h30000);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        load_row_t dir [18];
        load_row_t r;
        placement_t err_beat, single_beat;
        int items, n, k, choice;
        bit saturated_done;
        logic [31:0] cfg_val;

        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_func = 1'b0;
        s_run_length = '0;
        s_correction = '0;
        s_user_bin = '0;
        s_count = '0;
        s_last = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        err_beat = '0;
        err_beat.err = 1'b1;
        err_beat.eor = 1'b1;
        single_beat = '0;
        single_beat.id = 16'hFFFF;
        single_beat.run = 7'd1;
        single_beat.eor = 1'b1;

        dir[0]  = mk_row(ROW_CFG,  FUNC_CORR, 7'd0, 32'd0, 16'(ADDR_TECH_BINS), 0, 0);
        dir[1]  = mk_row(ROW_ITEM, FUNC_BIN,  7'd0, 0, 16'h1234, 32'd5, 1'b0);
        dir[2]  = mk_row(ROW_ITEM, FUNC_BIN,  7'd0, 0, 16'h0002, 32'd9, 1'b1);
        dir[2].typed = 1'b1;
        dir[2].want = err_beat;
        dir[3]  = mk_row(ROW_ITEM, FUNC_CORR, 7'd1, 32'h0001_0000, 0, 0, 1'b0);
        dir[4]  = mk_row(ROW_ITEM, FUNC_CORR, 7'd2, 32'hFFFF_FFFF, 0, 0, 1'b0);
        dir[5]  = mk_row(ROW_ITEM, FUNC_CORR, 7'd3, 32'd0, 0, 0, 1'b0);
        dir[6]  = mk_row(ROW_ITEM, FUNC_CORR, 7'd4, 32'h0001_8000, 0, 0, 1'b0);
        // Out-of-range lengths and last on a correction beat are ignored.
        dir[7]  = mk_row(ROW_ITEM, FUNC_CORR, 7'd0, 32'hDEAD_BEEF, 16'hFFFF, 32'hFFFF_FFFF,
                         1'b1);
        dir[8]  = mk_row(ROW_ITEM, FUNC_CORR, 7'd127, 32'h1234_5678, 0, 0, 1'b0);
        dir[9]  = mk_row(ROW_ITEM, FUNC_BIN,  7'd0, 0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        dir[9].typed = 1'b1;
        dir[9].want = single_beat;
        dir[10] = mk_row(ROW_CFG,  FUNC_CORR, 7'd0, 32'd3, 16'(ADDR_UNUSED), 0, 0);
        dir[11] = mk_row(ROW_CFG,  FUNC_CORR, 7'd0, 32'd4, 16'(ADDR_TECH_BINS), 0, 0);
        dir[12] = mk_row(ROW_ITEM, FUNC_BIN,  7'd0, 0, 16'h0001, 32'd0, 1'b0);
        dir[13] = mk_row(ROW_ITEM, FUNC_BIN,  7'd0, 0, 16'h8000, 32'hFFFF_FFFF, 1'b0);
        dir[14] = mk_row(ROW_ITEM, FUNC_BIN,  7'd0, 0, 16'h7FFF, 32'd7, 1'b1);
        dir[15] = mk_row(ROW_ITEM, FUNC_BIN,  7'd0, 0, 16'hAAAA, 32'd100, 1'b0);
        dir[16] = mk_row(ROW_ITEM, FUNC_BIN,  7'd0, 0, 16'h5555, 32'd100, 1'b1);
        // 200 masks to 72, which clamps to the maximum bin count.
        dir[17] = mk_row(ROW_CFG,  FUNC_CORR, 7'd0, 32'd200, 16'(ADDR_TECH_BINS), 0, 0);

        foreach (dir[i]) begin
            if (dir[i].kind == ROW_ITEM) begin
                offer_q.push_back(dir[i]);
            end else begin
                flush_offers();
                write_tech_bins(dir[i].id[2:0], dir[i].corr);
            end
        end
        flush_offers();

        // Fill the whole correction table before any random layout.
        items = 0;
        for (k = 1; k <= CORR_DEPTH; k++) begin
            offer_q.push_back(mk_row(ROW_ITEM, FUNC_CORR, 7'(k), pick_corr(), 16'($urandom),
                                     $urandom, 1'($urandom_range(0, 1))));
            items++;
        end
        flush_offers();

        write_tech_bins(ADDR_TECH_BINS, 32'd8);
        hold_req = 1;
        for (k = 0; k < 4; k++) begin
            offer_q.push_back(mk_row(ROW_ITEM, FUNC_BIN, 7'($urandom), $urandom,
                                     16'($urandom), pick_count(), k == 3));
            items++;
        end
        // A second layout follows at once, so it waits behind the held results.
        for (k = 0; k < 2; k++) begin
            offer_q.push_back(mk_row(ROW_ITEM, FUNC_BIN, 7'($urandom), $urandom,
                                     16'($urandom), pick_count(), k == 1));
            items++;
        end
        flush_offers();

        saturated_done = 0;
        while (items < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 2) begin
                choice = $urandom_range(0, 7);
                case (choice)
                    0: cfg_val = 32'd1;
                    1: cfg_val = 32'd64;
                    2: cfg_val = 32'd0;
                    3: cfg_val = 32'd127;
                    4: cfg_val = $urandom;
                    default: cfg_val = $urandom_range(2, 16);
                endcase
                write_tech_bins(ADDR_TECH_BINS, cfg_val);
            end
            if (!saturated_done && items > ITEM_TARGET / 2) begin
                n = USER_MAX + 2;
                saturated_done = 1;
            end else if ($urandom_range(0, 9) == 0) begin
                n = tech_bins + $urandom_range(1, 3);
                if (n > USER_MAX + 1) n = USER_MAX + 1;
            end else if (tech_bins > 16) begin
                n = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 2)
                                                 : $urandom_range(tech_bins - 4, tech_bins);
            end else begin
                n = $urandom_range(1, (tech_bins < 6) ? tech_bins : 6);
            end
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    if ($urandom_range(0, 1) == 0) begin
                        r = mk_row(ROW_ITEM, FUNC_CORR, 7'($urandom_range(1, CORR_DEPTH)),
                                   pick_corr(), 16'($urandom), $urandom,
                                   1'($urandom_range(0, 1)));
                    end else begin
                        r = mk_row(ROW_ITEM, FUNC_CORR,
                                   ($urandom_range(0, 1) == 0) ? 7'd0
                                                               : 7'($urandom_range(65, 127)),
                                   $urandom, 16'($urandom), $urandom,
                                   1'($urandom_range(0, 1)));
                    end
                    items++;
                    offer_q.push_back(r);
                end
                offer_q.push_back(mk_row(ROW_ITEM, FUNC_BIN, 7'($urandom), $urandom,
                                         16'($urandom), pick_count(), k == n - 1));
                items++;
            end
            flush_offers();
        end

        @(negedge aclk);
        while (pending_placements.size() != 0) @(negedge aclk);
        repeat (100) @(posedge aclk);
        if (failures == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== minmax_bin_partition_dp.f =====
+incdir+rtl
rtl/mmbp_pkg.sv
rtl/mmbp_div.sv
rtl/minmax_bin_partition_dp.sv
rtl/mmbp_checker.sv
test/minmax_bin_partition_dp_test.sv
